[sv/spdic_pkg.sv]
// Package with the shared types, port codes and helpers of the system port decoder.
package spdic_pkg;

  localparam logic [7:0] OPEN_BUS_BYTE = 8'h90;
  localparam logic [7:0] SYS_CTL2_MASK = 8'hEF;
  localparam logic [7:0] VEC_BASE_MASK = 8'hF8;
  localparam logic [7:0] OPEN_LOW_START = 8'hB7;
  localparam logic [7:0] EEPROM_BASE = 8'hBA;
  localparam logic [7:0] CRYSTAL_ID = 8'h80;
  localparam logic [7:0] NMI_READ_BIT = 8'h10;

  localparam logic [7:0] PORT_SYS_CTL2 = 8'h60;
  localparam logic [7:0] PORT_POWER = 8'h62;
  localparam logic [7:0] PORT_SYS_CTL1 = 8'hA0;
  localparam logic [7:0] PORT_VEC_BASE = 8'hB0;
  localparam logic [7:0] PORT_SERIAL_DATA = 8'hB1;
  localparam logic [7:0] PORT_IRQ_ENABLE = 8'hB2;
  localparam logic [7:0] PORT_SERIAL_CTL = 8'hB3;
  localparam logic [7:0] PORT_IRQ_ACTIVE = 8'hB4;
  localparam logic [7:0] PORT_KEYPAD = 8'hB5;
  localparam logic [7:0] PORT_IRQ_ACK = 8'hB6;
  localparam logic [7:0] PORT_NMI_CTL = 8'hB7;

  localparam logic [3:0] UNIT_INTERNAL = 4'd0;
  localparam logic [3:0] UNIT_VIDEO = 4'd1;
  localparam logic [3:0] UNIT_DMA = 4'd2;
  localparam logic [3:0] UNIT_VOICE = 4'd3;
  localparam logic [3:0] UNIT_LCD = 4'd4;
  localparam logic [3:0] UNIT_SOUND = 4'd5;
  localparam logic [3:0] UNIT_TIMER = 4'd6;
  localparam logic [3:0] UNIT_EEPROM = 4'd7;
  localparam logic [3:0] UNIT_CART = 4'd8;
  localparam logic [3:0] UNIT_SERIAL = 4'd9;
  localparam logic [3:0] UNIT_KEYPAD = 4'd10;
  localparam logic [3:0] UNIT_OPEN = 4'd11;

  localparam logic [1:0] MODEL_MONO = 2'd0;
  localparam logic [1:0] MODEL_CRYSTAL = 2'd2;

  typedef enum logic [1:0] {
    OP_READ = 2'd0,
    OP_WRITE = 2'd1,
    OP_RAISE = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] port;
    logic [7:0]  write_data;
    logic        word_access;
    logic [7:0]  irq_sources;
    logic        uart_send_pending;
  } item_t;

  typedef struct packed {
    logic [7:0] sys_ctl2;
    logic       four_bpp_on;
    logic       four_bpp_packed;
    logic       color_flag;
    logic       boot_off;
    logic [3:0] speed;
    logic [7:0] irq_enable;
    logic [7:0] irq_active;
    logic [7:0] vec_base;
    logic       nmi_on;
  } state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] target_unit;
    logic [7:0] unit_port;
    logic [7:0] active_irqs;
    logic [7:0] irq_vector;
    logic [1:0] video_mode;
    logic       color_on;
    logic       boot_rom_off;
    logic       cart_word_wide;
    logic       rom_slow;
    logic       sram_slow;
    logic       cart_port_slow;
  } result_t;

  function automatic logic [7:0] irq_vector_of(input logic [7:0] active,
                                               input logic [7:0] base);
    logic [2:0] idx;
    logic       found;
    idx = 3'd0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && active[i]) begin
        idx = 3'(i);
        found = 1'b1;
      end
    end
    return found ? base + {5'd0, idx} : base;
  endfunction

  function automatic logic [1:0] video_mode_of(input state_t st);
    logic [1:0] mode;
    if (!st.color_flag) begin
      mode = 2'd0;
    end else if (!st.four_bpp_on) begin
      mode = 2'd1;
    end else begin
      mode = st.four_bpp_packed ? 2'd3 : 2'd2;
    end
    return mode;
  endfunction

endpackage

[sv/spdic_decode.sv]
// Port decode, internal register update and interrupt latch logic for one item.
module spdic_decode (
  input  spdic_pkg::item_t   item,
  input  spdic_pkg::state_t  st,
  input  logic [1:0]         model,
  output spdic_pkg::result_t res,
  output spdic_pkg::state_t  st_next
);

  logic       mono;
  logic       crystal;
  logic       is_write;
  logic [7:0] p;
  logic [7:0] v;
  logic [7:0] act0;
  logic [3:0] unit;
  logic [7:0] uport;
  logic [7:0] rd;
  spdic_pkg::state_t ns;

  assign mono = (model == spdic_pkg::MODEL_MONO);
  assign crystal = (model == spdic_pkg::MODEL_CRYSTAL);
  assign is_write = (item.opcode == spdic_pkg::OP_WRITE);
  assign p = item.port[7:0];
  assign v = item.write_data;
  assign act0 = st.irq_active | {7'd0, item.uart_send_pending & st.irq_enable[0]};

  always_comb begin
    ns = st;
    ns.irq_active = act0;
    unit = spdic_pkg::UNIT_INTERNAL;
    uport = 8'd0;
    rd = 8'd0;
    unique case (item.opcode)
      spdic_pkg::OP_READ, spdic_pkg::OP_WRITE: begin
        uport = p;
        priority if (item.port[8] ||
                     (item.port[15:8] != 8'd0 && p >= spdic_pkg::OPEN_LOW_START)) begin
          unit = spdic_pkg::UNIT_OPEN;
          rd = is_write ? 8'd0 : spdic_pkg::OPEN_BUS_BYTE;
        end else if (p <= 8'h3F) begin
          unit = spdic_pkg::UNIT_VIDEO;
        end else if (p >= 8'h40 && p <= 8'h53 && st.color_flag) begin
          unit = spdic_pkg::UNIT_DMA;
        end else if (p >= 8'h64 && p <= 8'h6B && st.color_flag) begin
          unit = spdic_pkg::UNIT_VOICE;
        end else if (p >= 8'h70 && p <= 8'h77 && crystal && (!is_write || !st.boot_off)) begin
          unit = spdic_pkg::UNIT_LCD;
        end else if (p >= 8'h80 && p <= 8'h9F) begin
          unit = spdic_pkg::UNIT_SOUND;
        end else if (p >= 8'hA2 && p <= 8'hAB) begin
          unit = spdic_pkg::UNIT_TIMER;
        end else if (p >= spdic_pkg::EEPROM_BASE) begin
          if (p >= 8'hC0) begin
            unit = spdic_pkg::UNIT_CART;
          end else if (!mono || item.word_access || !p[0]) begin
            unit = spdic_pkg::UNIT_EEPROM;
            uport = p - spdic_pkg::EEPROM_BASE;
          end else begin
            unit = spdic_pkg::UNIT_OPEN;
            rd = is_write ? 8'd0 : spdic_pkg::OPEN_BUS_BYTE;
          end
        end else if (p == spdic_pkg::PORT_SERIAL_DATA || p == spdic_pkg::PORT_SERIAL_CTL) begin
          unit = spdic_pkg::UNIT_SERIAL;
        end else if (p == spdic_pkg::PORT_KEYPAD) begin
          unit = spdic_pkg::UNIT_KEYPAD;
        end else if (is_write) begin
          unique case (p)
            spdic_pkg::PORT_SYS_CTL2: begin
              if (!mono) begin
                ns.sys_ctl2 = v & spdic_pkg::SYS_CTL2_MASK;
                ns.color_flag = v[7];
                ns.four_bpp_on = v[6];
                ns.four_bpp_packed = v[5];
                ns.speed[2] = v[1];
                ns.speed[3] = v[3];
              end
            end
            spdic_pkg::PORT_POWER: begin
              unit = spdic_pkg::UNIT_INTERNAL;
            end
            spdic_pkg::PORT_SYS_CTL1: begin
              ns.boot_off = st.boot_off | v[0];
              ns.speed[0] = v[2];
              ns.speed[1] = v[3];
            end
            spdic_pkg::PORT_VEC_BASE: ns.vec_base = v & spdic_pkg::VEC_BASE_MASK;
            spdic_pkg::PORT_IRQ_ENABLE: ns.irq_enable = v;
            spdic_pkg::PORT_IRQ_ACK: ns.irq_active = act0 & ~v;
            spdic_pkg::PORT_NMI_CTL: ns.nmi_on = v[4];
            default: unit = spdic_pkg::UNIT_OPEN;
          endcase
        end else begin
          unique case (p)
            spdic_pkg::PORT_SYS_CTL2: rd = st.sys_ctl2;
            spdic_pkg::PORT_POWER: rd = crystal ? spdic_pkg::CRYSTAL_ID : 8'd0;
            spdic_pkg::PORT_SYS_CTL1: rd = {1'b1, 3'd0, st.speed[1], st.speed[0], !mono,
                                            st.boot_off};
            spdic_pkg::PORT_VEC_BASE: rd = spdic_pkg::irq_vector_of(act0, st.vec_base);
            spdic_pkg::PORT_IRQ_ENABLE: rd = st.irq_enable;
            spdic_pkg::PORT_IRQ_ACTIVE: rd = act0;
            spdic_pkg::PORT_NMI_CTL: rd = st.nmi_on ? spdic_pkg::NMI_READ_BIT : 8'd0;
            default: begin
              unit = spdic_pkg::UNIT_OPEN;
              rd = spdic_pkg::OPEN_BUS_BYTE;
            end
          endcase
        end
      end
      spdic_pkg::OP_RAISE: ns.irq_active = act0 | (item.irq_sources & st.irq_enable);
      spdic_pkg::OP_CLEAR: ns.irq_active = act0 & ~item.irq_sources;
    endcase
  end

  assign st_next = ns;

  always_comb begin
    res.read_data = rd;
    res.target_unit = unit;
    res.unit_port = uport;
    res.active_irqs = ns.irq_active;
    res.irq_vector = spdic_pkg::irq_vector_of(ns.irq_active, ns.vec_base);
    res.video_mode = spdic_pkg::video_mode_of(ns);
    res.color_on = ns.color_flag;
    res.boot_rom_off = ns.boot_off;
    res.cart_word_wide = ns.speed[0];
    res.rom_slow = ns.speed[1];
    res.sram_slow = ns.speed[2];
    res.cart_port_slow = ns.speed[3];
  end

endmodule

[sv/system_port_decode_irq_controller.sv]
// Top level of the system port decoder and interrupt controller.
//   Channel  Handshake              Carries
//   input    in_valid / in_ready    opcode, port, write_data, word_access, irq_sources,
//                                   uart_send_pending
//   output   out_valid / out_ready  read_data .. cart_port_slow
//   config   APB psel / penable     machine_model at byte address 0
// An item is registered on entry and then decoded into the result register, which offers
// its result; one item is taken every cycle while the output is not stalled.
// The internal registers update as an item moves into the result register.
// A stalled output holds its result and input stage; reset clears flags, state, model.
module system_port_decode_irq_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] port,
  input  logic [7:0]  write_data,
  input  logic        word_access,
  input  logic [7:0]  irq_sources,
  input  logic        uart_send_pending,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [3:0]  target_unit,
  output logic [7:0]  unit_port,
  output logic [7:0]  active_irqs,
  output logic [7:0]  irq_vector,
  output logic [1:0]  video_mode,
  output logic        color_on,
  output logic        boot_rom_off,
  output logic        cart_word_wide,
  output logic        rom_slow,
  output logic        sram_slow,
  output logic        cart_port_slow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]         model;
  logic               s1_valid;
  spdic_pkg::item_t   s1_item;
  spdic_pkg::state_t  st;
  spdic_pkg::state_t  st_next;
  spdic_pkg::result_t res_next;
  spdic_pkg::result_t res;
  logic               out_load;
  logic               in_take;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {30'd0, model};

  always_ff @(posedge clk) begin
    if (rst) begin
      model <= spdic_pkg::MODEL_MONO;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      model <= pwdata[1:0];
    end
  end

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;
  assign in_take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !out_load);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= '{opcode: spdic_pkg::opcode_t'(opcode), port: port,
                   write_data: write_data, word_access: word_access,
                   irq_sources: irq_sources, uart_send_pending: uart_send_pending};
    end
  end

  spdic_decode u_decode (
    .item    (s1_item),
    .st      (st),
    .model   (model),
    .res     (res_next),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        st <= st_next;
      end
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= res_next;
    end
  end

  assign read_data = res.read_data;
  assign target_unit = res.target_unit;
  assign unit_port = res.unit_port;
  assign active_irqs = res.active_irqs;
  assign irq_vector = res.irq_vector;
  assign video_mode = res.video_mode;
  assign color_on = res.color_on;
  assign boot_rom_off = res.boot_rom_off;
  assign cart_word_wide = res.cart_word_wide;
  assign rom_slow = res.rom_slow;
  assign sram_slow = res.sram_slow;
  assign cart_port_slow = res.cart_port_slow;

`ifndef SYNTH
  a_boot_sticky: assert property (@(posedge clk) disable iff (rst)
    st.boot_off |=> st.boot_off)
    else $error("boot ROM disable bit was cleared");

  a_vec_base_aligned: assert property (@(posedge clk) disable iff (rst)
    st.vec_base[2:0] == 3'd0)
    else $error("vector base has low bits set");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled while the pipeline has room");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (target_unit <= spdic_pkg::UNIT_OPEN))
    else $error("target unit code out of range");
`endif

endmodule

[sim/tb_system_port_decode_irq_controller.sv]
`timescale 1ns / 1ps
// Testbench for the system port decoder and interrupt controller: queued stimulus, scoreboard.
module tb_system_port_decode_irq_controller;

  localparam logic [2:0] MODEL_REG_ADDR = 3'd0;
  localparam logic [1:0] MODEL_COLOR = 2'd1;
  localparam logic [1:0] MODEL_SPARE = 2'd3;
  localparam logic [1:0] VMODE_MONO = 2'd0;
  localparam logic [1:0] VMODE_2BPP = 2'd1;
  localparam logic [1:0] VMODE_4BPP = 2'd2;
  localparam logic [1:0] VMODE_PACKED = 2'd3;
  localparam int RX_ALWAYS = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_PATTERN = 2;
  localparam int HOT_PORT_COUNT = 39;
  localparam int PHASE_COUNT = 6;
  localparam int RANDOM_PER_PHASE = 280;

  typedef struct packed {
    spdic_pkg::item_t item;
    logic             drain_before;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = 2'd0;
  logic [15:0] port = 16'd0;
  logic [7:0]  write_data = 8'd0;
  logic        word_access = 1'b0;
  logic [7:0]  irq_sources = 8'd0;
  logic        uart_send_pending = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic [3:0]  target_unit;
  logic [7:0]  unit_port;
  logic [7:0]  active_irqs;
  logic [7:0]  irq_vector;
  logic [1:0]  video_mode;
  logic        color_on;
  logic        boot_rom_off;
  logic        cart_word_wide;
  logic        rom_slow;
  logic        sram_slow;
  logic        cart_port_slow;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  system_port_decode_irq_controller uut (.*);

  // Scoreboard copy of the block's registers.
  logic [1:0] model_cfg = 2'd0;
  logic [7:0] ctl2_reg = 8'd0;
  logic       four_bpp = 1'b0;
  logic       packed_px = 1'b0;
  logic       color_mode = 1'b0;
  logic       boot_locked = 1'b0;
  logic [3:0] bus_speed = 4'd0;
  logic [7:0] irq_enable_bits = 8'd0;
  logic [7:0] irq_latched = 8'd0;
  logic [7:0] vector_base = 8'd0;
  logic       nmi_armed = 1'b0;

  stim_t              bus_items_q[$];
  spdic_pkg::result_t port_result_q[$];
  spdic_pkg::item_t   offered_item;
  bit                 item_offered = 1'b0;
  bit                 sender_bursty = 1'b0;
  int                 burst_left = 0;
  int                 gap_left = 0;
  int                 ready_mode = RX_ALWAYS;
  int                 hold_off_left = 0;
  int                 rx_tick = 0;
  int                 mismatch_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("system_port_decode_irq_controller test failed");
    $finish;
  end

  function automatic logic [7:0] irq_vector_now();
    logic [7:0] v;
    v = vector_base;
    for (int b = 0; b < 8; b++) begin
      if (irq_latched[b]) v = vector_base + 8'(b);
    end
    return v;
  endfunction

  function automatic spdic_pkg::result_t decode_port_item(input spdic_pkg::item_t it);
    spdic_pkg::result_t r;
    logic [7:0] lo;
    logic is_wr;
    logic mono;
    logic crystal;
    r = '0;
    lo = it.port[7:0];
    is_wr = (it.opcode == spdic_pkg::OP_WRITE);
    mono = (model_cfg == spdic_pkg::MODEL_MONO);
    crystal = (model_cfg == spdic_pkg::MODEL_CRYSTAL);
    if (it.uart_send_pending && irq_enable_bits[0]) irq_latched[0] = 1'b1;
    if (it.opcode == spdic_pkg::OP_RAISE) begin
      irq_latched = irq_latched | (it.irq_sources & irq_enable_bits);
    end else if (it.opcode == spdic_pkg::OP_CLEAR) begin
      irq_latched = irq_latched & ~it.irq_sources;
    end else begin
      r.unit_port = lo;
      r.target_unit = spdic_pkg::UNIT_INTERNAL;
      if (it.port[8] || (it.port[15:8] != 8'd0 && lo >= spdic_pkg::OPEN_LOW_START)) begin
        r.target_unit = spdic_pkg::UNIT_OPEN;
        r.read_data = spdic_pkg::OPEN_BUS_BYTE;
      end else if (lo <= 8'h3F) begin
        r.target_unit = spdic_pkg::UNIT_VIDEO;
      end else if (lo >= 8'h40 && lo <= 8'h53 && color_mode) begin
        r.target_unit = spdic_pkg::UNIT_DMA;
      end else if (lo >= 8'h64 && lo <= 8'h6B && color_mode) begin
        r.target_unit = spdic_pkg::UNIT_VOICE;
      end else if (lo >= 8'h70 && lo <= 8'h77 && crystal && (!is_wr || !boot_locked)) begin
        r.target_unit = spdic_pkg::UNIT_LCD;
      end else if (lo >= 8'h80 && lo <= 8'h9F) begin
        r.target_unit = spdic_pkg::UNIT_SOUND;
      end else if (lo >= 8'hA2 && lo <= 8'hAB) begin
        r.target_unit = spdic_pkg::UNIT_TIMER;
      end else if (lo >= spdic_pkg::EEPROM_BASE && lo <= 8'hBF) begin
        if (!mono || it.word_access || !lo[0]) begin
          r.target_unit = spdic_pkg::UNIT_EEPROM;
          r.unit_port = lo - spdic_pkg::EEPROM_BASE;
        end else begin
          r.target_unit = spdic_pkg::UNIT_OPEN;
          r.read_data = spdic_pkg::OPEN_BUS_BYTE;
        end
      end else if (lo >= 8'hC0) begin
        r.target_unit = spdic_pkg::UNIT_CART;
      end else if (lo == spdic_pkg::PORT_SERIAL_DATA || lo == spdic_pkg::PORT_SERIAL_CTL) begin
        r.target_unit = spdic_pkg::UNIT_SERIAL;
      end else if (lo == spdic_pkg::PORT_KEYPAD) begin
        r.target_unit = spdic_pkg::UNIT_KEYPAD;
      end else if (is_wr) begin
        case (lo)
          spdic_pkg::PORT_SYS_CTL2: begin
            if (!mono) begin
              ctl2_reg = it.write_data & spdic_pkg::SYS_CTL2_MASK;
              color_mode = it.write_data[7];
              four_bpp = it.write_data[6];
              packed_px = it.write_data[5];
              bus_speed[2] = it.write_data[1];
              bus_speed[3] = it.write_data[3];
            end
          end
          spdic_pkg::PORT_POWER: ;
          spdic_pkg::PORT_SYS_CTL1: begin
            boot_locked = boot_locked | it.write_data[0];
            bus_speed[0] = it.write_data[2];
            bus_speed[1] = it.write_data[3];
          end
          spdic_pkg::PORT_VEC_BASE: vector_base = it.write_data & spdic_pkg::VEC_BASE_MASK;
          spdic_pkg::PORT_IRQ_ENABLE: irq_enable_bits = it.write_data;
          spdic_pkg::PORT_IRQ_ACK: irq_latched = irq_latched & ~it.write_data;
          spdic_pkg::PORT_NMI_CTL: nmi_armed = it.write_data[4];
          default: r.target_unit = spdic_pkg::UNIT_OPEN;
        endcase
      end else begin
        case (lo)
          spdic_pkg::PORT_SYS_CTL2: r.read_data = ctl2_reg;
          spdic_pkg::PORT_POWER: r.read_data = crystal ? spdic_pkg::CRYSTAL_ID : 8'h00;
          spdic_pkg::PORT_SYS_CTL1: r.read_data = {1'b1, 3'b000, bus_speed[1], bus_speed[0],
                                                   ~mono, boot_locked};
          spdic_pkg::PORT_VEC_BASE: r.read_data = irq_vector_now();
          spdic_pkg::PORT_IRQ_ENABLE: r.read_data = irq_enable_bits;
          spdic_pkg::PORT_IRQ_ACTIVE: r.read_data = irq_latched;
          spdic_pkg::PORT_NMI_CTL: r.read_data = nmi_armed ? spdic_pkg::NMI_READ_BIT : 8'h00;
          default: begin
            r.target_unit = spdic_pkg::UNIT_OPEN;
            r.read_data = spdic_pkg::OPEN_BUS_BYTE;
          end
        endcase
      end
      if (is_wr) r.read_data = 8'h00;
    end
    r.active_irqs = irq_latched;
    r.irq_vector = irq_vector_now();
    r.video_mode = !color_mode ? VMODE_MONO : !four_bpp ? VMODE_2BPP :
                   packed_px ? VMODE_PACKED : VMODE_4BPP;
    r.color_on = color_mode;
    r.boot_rom_off = boot_locked;
    r.cart_word_wide = bus_speed[0];
    r.rom_slow = bus_speed[1];
    r.sram_slow = bus_speed[2];
    r.cart_port_slow = bus_speed[3];
    return r;
  endfunction

  function automatic logic [7:0] hot_low_byte(input int k);
    case (k)
      0: return spdic_pkg::PORT_SYS_CTL2;
      1: return spdic_pkg::PORT_POWER;
      2: return spdic_pkg::PORT_SYS_CTL1;
      3: return spdic_pkg::PORT_VEC_BASE;
      4: return spdic_pkg::PORT_SERIAL_DATA;
      5: return spdic_pkg::PORT_IRQ_ENABLE;
      6: return spdic_pkg::PORT_IRQ_ENABLE;
      7: return spdic_pkg::PORT_SERIAL_CTL;
      8: return spdic_pkg::PORT_IRQ_ACTIVE;
      9: return spdic_pkg::PORT_KEYPAD;
      10: return spdic_pkg::PORT_IRQ_ACK;
      11: return spdic_pkg::PORT_NMI_CTL;
      12: return 8'h3F;
      13: return 8'h40;
      14: return 8'h53;
      15: return 8'h54;
      16: return 8'h63;
      17: return 8'h64;
      18: return 8'h6B;
      19: return 8'h6C;
      20: return 8'h70;
      21: return 8'h77;
      22: return 8'h78;
      23: return 8'h80;
      24: return 8'h9F;
      25: return 8'hA1;
      26: return 8'hA2;
      27: return 8'hAB;
      28: return 8'hAC;
      29: return 8'hB8;
      30: return 8'hB9;
      31: return 8'hBA;
      32: return 8'hBB;
      33: return 8'hBC;
      34: return 8'hBD;
      35: return 8'hBE;
      36: return 8'hBF;
      37: return 8'hC0;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic spdic_pkg::item_t random_access(input bit keep_boot);
    spdic_pkg::item_t it;
    int pick;
    logic [7:0] lo;
    pick = $urandom_range(99);
    if (pick < 35) it.opcode = spdic_pkg::OP_READ;
    else if (pick < 70) it.opcode = spdic_pkg::OP_WRITE;
    else if (pick < 85) it.opcode = spdic_pkg::OP_RAISE;
    else it.opcode = spdic_pkg::OP_CLEAR;
    lo = ($urandom_range(99) < 45) ? hot_low_byte($urandom_range(HOT_PORT_COUNT - 1))
                                   : 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 75) it.port = {8'h00, lo};
    else if (pick < 90) it.port = {7'($urandom), 1'b0, lo};
    else it.port = 16'($urandom);
    it.write_data = 8'($urandom);
    // The boot ROM stays enabled during the first phase so that panel writes get through.
    if (keep_boot && it.port[7:0] == spdic_pkg::PORT_SYS_CTL1) it.write_data[0] = 1'b0;
    it.word_access = 1'($urandom);
    it.irq_sources = 8'($urandom);
    it.uart_send_pending = ($urandom_range(3) == 0);
    return it;
  endfunction

  task automatic push_op(input spdic_pkg::opcode_t op, input logic [15:0] p,
                         input logic [7:0] d, input logic w, input logic [7:0] src,
                         input logic uart);
    stim_t s;
    s.item.opcode = op;
    s.item.port = p;
    s.item.write_data = d;
    s.item.word_access = w;
    s.item.irq_sources = src;
    s.item.uart_send_pending = uart;
    s.drain_before = 1'b0;
    bus_items_q.push_back(s);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch in %s: expected %02h, got %02h", name, want, got);
    end
  endtask

  task automatic write_model(input logic [1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODEL_REG_ADDR;
    pwdata <= {30'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    model_cfg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("machine_model readback", {6'd0, value}, {6'd0, prdata[1:0]});
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (bus_items_q.size() != 0 || item_offered || port_result_q.size() != 0)
      @(negedge clk);
  endtask

  always @(negedge clk) begin : driver
    stim_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_offered) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (bus_items_q.size() == 0 ||
                   (bus_items_q[0].drain_before && port_result_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        nxt = bus_items_q.pop_front();
        offered_item = nxt.item;
        item_offered = 1'b1;
        in_valid <= 1'b1;
        opcode <= nxt.item.opcode;
        port <= nxt.item.port;
        write_data <= nxt.item.write_data;
        word_access <= nxt.item.word_access;
        irq_sources <= nxt.item.irq_sources;
        uart_send_pending <= nxt.item.uart_send_pending;
        if (sender_bursty) begin
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            gap_left = $urandom_range(1, 8);
            burst_left = $urandom_range(0, 15);
          end
        end
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else begin
      rx_tick++;
      case (ready_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(99) < 65);
        default: out_ready <= (rx_tick % 5 != 2) && (rx_tick % 11 != 7);
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    spdic_pkg::result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (port_result_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result with none expected: unit %0d port %02h", target_unit, unit_port);
        end else begin
          want = port_result_q.pop_front();
          check_field("read_data", want.read_data, read_data);
          check_field("target_unit", {4'd0, want.target_unit}, {4'd0, target_unit});
          check_field("unit_port", want.unit_port, unit_port);
          check_field("active_irqs", want.active_irqs, active_irqs);
          check_field("irq_vector", want.irq_vector, irq_vector);
          check_field("video_mode", {6'd0, want.video_mode}, {6'd0, video_mode});
          check_field("color_on", {7'd0, want.color_on}, {7'd0, color_on});
          check_field("boot_rom_off", {7'd0, want.boot_rom_off}, {7'd0, boot_rom_off});
          check_field("cart_word_wide", {7'd0, want.cart_word_wide}, {7'd0, cart_word_wide});
          check_field("rom_slow", {7'd0, want.rom_slow}, {7'd0, rom_slow});
          check_field("sram_slow", {7'd0, want.sram_slow}, {7'd0, sram_slow});
          check_field("cart_port_slow", {7'd0, want.cart_port_slow}, {7'd0, cart_port_slow});
        end
      end
      if (in_valid && in_ready) begin
        port_result_q.push_back(decode_port_item(offered_item));
        item_offered = 1'b0;
      end
    end
  end

  initial begin : stimulus
    stim_t s;
    logic [1:0] phase_model;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_quiet();
      repeat (3) @(posedge clk);
      case (ph)
        0: phase_model = spdic_pkg::MODEL_CRYSTAL;
        1: phase_model = spdic_pkg::MODEL_MONO;
        2: phase_model = MODEL_COLOR;
        3: phase_model = MODEL_SPARE;
        4: phase_model = spdic_pkg::MODEL_MONO;
        default: phase_model = spdic_pkg::MODEL_CRYSTAL;
      endcase
      write_model(phase_model);
      @(posedge clk);
      sender_bursty = (ph % 2 == 1);
      ready_mode = ph % 3;
      if (ph == 0) begin
        push_op(spdic_pkg::OP_WRITE, {8'h00, spdic_pkg::PORT_IRQ_ENABLE}, 8'hFF, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, {8'h00, spdic_pkg::PORT_IRQ_ENABLE}, 8'h00, 1'b0,
                8'h00, 1'b1);
        push_op(spdic_pkg::OP_RAISE, 16'h0000, 8'h00, 1'b0, 8'h81, 1'b0);
        push_op(spdic_pkg::OP_READ, {8'h00, spdic_pkg::PORT_IRQ_ACTIVE}, 8'h00, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_WRITE, {8'h00, spdic_pkg::PORT_VEC_BASE}, 8'hFF, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, {8'h00, spdic_pkg::PORT_VEC_BASE}, 8'h00, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_WRITE, {8'h00, spdic_pkg::PORT_IRQ_ACK}, 8'h80, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_CLEAR, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 1'b0);
        push_op(spdic_pkg::OP_WRITE, {8'h00, spdic_pkg::PORT_SYS_CTL2}, 8'hFF, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, {8'h00, spdic_pkg::PORT_SYS_CTL2}, 8'h00, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_WRITE, {8'h00, spdic_pkg::PORT_SYS_CTL2}, 8'hC0, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, {8'h00, spdic_pkg::PORT_POWER}, 8'h00, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_WRITE, {8'h00, spdic_pkg::PORT_POWER}, 8'hFF, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_WRITE, 16'h0070, 8'h5A, 1'b0, 8'h00, 1'b0);
        push_op(spdic_pkg::OP_WRITE, {8'h00, spdic_pkg::PORT_NMI_CTL}, 8'h10, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, {8'h00, spdic_pkg::PORT_NMI_CTL}, 8'h00, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, 16'hFFFF, 8'h00, 1'b0, 8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, 16'h0100, 8'h00, 1'b0, 8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, 16'h02B6, 8'h00, 1'b0, 8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, 16'h0240, 8'h00, 1'b0, 8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, 16'h0064, 8'h00, 1'b0, 8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, 16'h00BB, 8'h00, 1'b0, 8'h00, 1'b0);
      end
      if (ph == 1) begin
        push_op(spdic_pkg::OP_READ, 16'h00BB, 8'h00, 1'b0, 8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, 16'h00BB, 8'h00, 1'b1, 8'h00, 1'b0);
        push_op(spdic_pkg::OP_WRITE, {8'h00, spdic_pkg::PORT_SYS_CTL2}, 8'h00, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, {8'h00, spdic_pkg::PORT_SYS_CTL1}, 8'h00, 1'b0,
                8'h00, 1'b0);
      end
      // Long output stall while items keep coming, so the input side backs up.
      if (ph == 2) hold_off_left = 80;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        s.item = random_access(ph == 0);
        s.drain_before = (ph == 3 && k == 120);
        bus_items_q.push_back(s);
      end
      if (ph == 0) begin
        push_op(spdic_pkg::OP_WRITE, {8'h00, spdic_pkg::PORT_SYS_CTL1}, 8'h0D, 1'b0,
                8'h00, 1'b0);
        push_op(spdic_pkg::OP_WRITE, 16'h0070, 8'hA5, 1'b0, 8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, 16'h0070, 8'h00, 1'b0, 8'h00, 1'b0);
        push_op(spdic_pkg::OP_READ, {8'h00, spdic_pkg::PORT_SYS_CTL1}, 8'h00, 1'b0,
                8'h00, 1'b0);
      end
    end
    wait_quiet();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && port_result_q.size() == 0) begin
      $display("system_port_decode_irq_controller test passed");
    end else begin
      $display("system_port_decode_irq_controller test failed");
    end
    $finish;
  end

endmodule
